@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the quaternion slerp RTL.
// No dependencies; expects clk and arst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked every clock, off while in reset
`define QS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// antecedent now implies consequent on the next clock
`define QS_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) pre |=> post) else $error(msg);

`endif

@@ hw/rtl/qslerp_pkg.sv @@
// Types, widths and the arctangent table for the quaternion slerp pipeline.
// No dependencies.
package qslerp_pkg;

	localparam int FRAC    = 14;
	localparam int ONE     = 1 << FRAC;
	localparam int IO_W    = 16;
	localparam int XY_W    = 20;
	localparam int Z_W     = 18;
	localparam int TF_W    = 15;
	localparam int C_W     = 15;
	localparam int SQ_W    = 30;
	localparam int ROOT_W  = 15;
	localparam int DOT_W   = 35;
	localparam int DIV_W   = 36;
	localparam int QUO_W   = 15;
	localparam int K_W     = 18;
	localparam int PROD_W  = K_W + IO_W;
	localparam int LIMIT_W = 15;
	localparam int ATAN_N  = 24;

	typedef enum logic [1:0] {
		MODE_PASS_P,
		MODE_PASS_Q,
		MODE_BLEND
	} mode_t;

	typedef struct packed {
		logic [3:0][IO_W-1:0] p;
		logic [3:0][IO_W-1:0] q;
		logic [TF_W-1:0]      tf;
		mode_t                mode;
		logic                 neg;
		logic                 lin;
	} side_t;

	localparam logic [31:0] ATAN_Q30 [ATAN_N] = '{
		32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
		32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
		32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536, 32'd32768,
		32'd16384, 32'd8192, 32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256, 32'd128
	};

	// atan(2^-i) in Q(FRAC), rounded half up from Q30
	function automatic logic signed [Z_W-1:0] atan_f(input int i);
		logic [32:0] v;
		v = {1'b0, ATAN_Q30[i]} + (33'd1 << (29 - FRAC));
		return Z_W'(v >> (30 - FRAC));
	endfunction

endpackage

@@ hw/rtl/qslerp_cordic.sv @@
// Pipelined CORDIC, one micro-rotation per register stage, LANES lanes in step.
// Depends on qslerp_pkg (widths, arctangent table).
module qslerp_cordic #(
	parameter int STEPS  = 16,
	parameter bit VECTOR = 1'b0,
	parameter int LANES  = 1,
	parameter int SIDE_W = 1
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic signed [qslerp_pkg::XY_W-1:0]  in_x [LANES],
	input  logic signed [qslerp_pkg::XY_W-1:0]  in_y [LANES],
	input  logic signed [qslerp_pkg::Z_W-1:0]   in_z [LANES],
	input  logic [SIDE_W-1:0]                   in_side,
	output logic                                out_valid,
	output logic signed [qslerp_pkg::XY_W-1:0]  out_x [LANES],
	output logic signed [qslerp_pkg::XY_W-1:0]  out_y [LANES],
	output logic signed [qslerp_pkg::Z_W-1:0]   out_z [LANES],
	output logic [SIDE_W-1:0]                   out_side
);
	import qslerp_pkg::*;

	localparam int N = (STEPS > ATAN_N) ? ATAN_N : STEPS;

	logic signed [XY_W-1:0] xs [N+1][LANES];
	logic signed [XY_W-1:0] ys [N+1][LANES];
	logic signed [Z_W-1:0]  zs [N+1][LANES];
	logic [SIDE_W-1:0]      side_s [N+1];
	logic [N:0]             v_s;

	assign v_s[0]    = in_valid;
	assign side_s[0] = in_side;

	genvar k, l;
	generate
		for (l = 0; l < LANES; l++) begin : g_in
			assign xs[0][l] = in_x[l];
			assign ys[0][l] = in_y[l];
			assign zs[0][l] = in_z[l];
			assign out_x[l] = xs[N][l];
			assign out_y[l] = ys[N][l];
			assign out_z[l] = zs[N][l];
		end
		for (k = 0; k < N; k++) begin : g_step
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s[k+1] <= 1'b0;
				end else begin
					v_s[k+1] <= v_s[k];
				end
			end
			always_ff @(posedge clk) begin
				side_s[k+1] <= side_s[k];
			end
			for (l = 0; l < LANES; l++) begin : g_lane
				logic ccw;
				logic signed [XY_W-1:0] dx, dy;
				assign ccw = VECTOR ? !(ys[k][l] > 0) : (zs[k][l] >= 0);
				assign dx  = ys[k][l] >>> k;
				assign dy  = xs[k][l] >>> k;
				always_ff @(posedge clk) begin
					if (ccw) begin
						xs[k+1][l] <= xs[k][l] - dx;
						ys[k+1][l] <= ys[k][l] + dy;
						zs[k+1][l] <= zs[k][l] - atan_f(k);
					end else begin
						xs[k+1][l] <= xs[k][l] + dx;
						ys[k+1][l] <= ys[k][l] - dy;
						zs[k+1][l] <= zs[k][l] + atan_f(k);
					end
				end
			end
		end
	endgenerate

	assign out_valid = v_s[N];
	assign out_side  = side_s[N];

endmodule

@@ hw/rtl/quaternion_slerp.sv @@
// Quaternion slerp top level: dot product, square root, CORDIC angle,
// CORDIC sines, two dividers and the weighted sum. Depends on qslerp_pkg,
// qslerp_cordic and assert_macros.svh.
//
// Fully pipelined: one item per clock, busy is never raised. From start to
// done the pipe holds eight single register stages, 15 stages each for the
// square root and the division at one bit per stage, plus the two CORDIC
// pipelines of one stage per step.
// done marks a single-cycle result beat; the receiver cannot stall, so there
// is no backpressure anywhere.
// cfg_ready is always high; write the limit only while the pipe is empty.
module quaternion_slerp #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic signed [qslerp_pkg::IO_W-1:0]    start_w,
	input  logic signed [qslerp_pkg::IO_W-1:0]    start_x,
	input  logic signed [qslerp_pkg::IO_W-1:0]    start_y,
	input  logic signed [qslerp_pkg::IO_W-1:0]    start_z,
	input  logic signed [qslerp_pkg::IO_W-1:0]    end_w,
	input  logic signed [qslerp_pkg::IO_W-1:0]    end_x,
	input  logic signed [qslerp_pkg::IO_W-1:0]    end_y,
	input  logic signed [qslerp_pkg::IO_W-1:0]    end_z,
	input  logic signed [qslerp_pkg::IO_W-1:0]    blend,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [qslerp_pkg::LIMIT_W-1:0]        cfg_data,
	output logic                                  done,
	output logic signed [qslerp_pkg::IO_W-1:0]    out_w,
	output logic signed [qslerp_pkg::IO_W-1:0]    out_x,
	output logic signed [qslerp_pkg::IO_W-1:0]    out_y,
	output logic signed [qslerp_pkg::IO_W-1:0]    out_z
);
	import qslerp_pkg::*;
	`include "assert_macros.svh"

	localparam int SIDE_W = $bits(side_t);
	localparam int SQ_N   = ROOT_W;
	localparam int DV_N   = QUO_W;

	logic [LIMIT_W-1:0] limit_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_W'(16382);
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= cfg_data;
		end
	end

	// stage 1: capture, mode, partial products
	logic                       v_s1;
	side_t                      side_s1;
	logic signed [2*IO_W-1:0]   prod_s1 [4];
	logic signed [IO_W-1:0]     p_in [4];
	logic signed [IO_W-1:0]     q_in [4];
	mode_t                      mode_in;

	assign p_in = '{start_w, start_x, start_y, start_z};
	assign q_in = '{end_w, end_x, end_y, end_z};

	always_comb begin
		if (blend <= 0) begin
			mode_in = MODE_PASS_P;
		end else if (blend >= IO_W'(ONE)) begin
			mode_in = MODE_PASS_Q;
		end else begin
			mode_in = MODE_BLEND;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			side_s1.p[i] <= p_in[i];
			side_s1.q[i] <= q_in[i];
			prod_s1[i]   <= p_in[i] * q_in[i];
		end
		side_s1.tf   <= TF_W'(blend);
		side_s1.mode <= mode_in;
		side_s1.neg  <= 1'b0;
		side_s1.lin  <= 1'b0;
	end

	// stage 2: dot product, sign fold, limit compare, cosine
	logic                     v_s2;
	side_t                    side_s2;
	side_t                    side_n2;
	logic [C_W-1:0]           c_s2;
	logic signed [DOT_W-1:0]  dot;
	logic [DOT_W-1:0]         adot;

	always_comb begin
		dot = DOT_W'(prod_s1[0]) + DOT_W'(prod_s1[1]) + DOT_W'(prod_s1[2])
			+ DOT_W'(prod_s1[3]);
		adot = (dot < 0) ? DOT_W'(-dot) : DOT_W'(dot);
		side_n2     = side_s1;
		side_n2.neg = dot < 0;
		side_n2.lin = adot > (DOT_W'(limit_q) << FRAC);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		side_s2 <= side_n2;
		c_s2 <= (adot >= (DOT_W'(1) << (2*FRAC))) ? C_W'(ONE) : adot[2*FRAC-1:FRAC];
	end

	// stage 3: c squared
	logic                  v_s3;
	side_t                 side_s3;
	logic [C_W-1:0]        c_s3;
	logic [2*C_W-1:0]      csq_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		side_s3 <= side_s2;
		c_s3    <= c_s2;
		csq_s3  <= c_s2 * c_s2;
	end

	// square root of ONE^2 - c^2, one root bit per stage
	logic [SQ_W-1:0]    sq_rem  [SQ_N+1];
	logic [ROOT_W-1:0]  sq_root [SQ_N+1];
	logic [C_W-1:0]     sq_c    [SQ_N+1];
	side_t              sq_side [SQ_N+1];
	logic [SQ_N:0]      sq_v;

	assign sq_rem[0]  = (SQ_W'(1) << (2*FRAC)) - SQ_W'(csq_s3);
	assign sq_root[0] = '0;
	assign sq_c[0]    = c_s3;
	assign sq_side[0] = side_s3;
	assign sq_v[0]    = v_s3;

	genvar j, l;
	generate
		for (j = 0; j < SQ_N; j++) begin : g_sqrt
			localparam int B = SQ_N - 1 - j;
			logic [SQ_W-1:0] delta;
			assign delta = (SQ_W'(sq_root[j]) << (B + 1)) + (SQ_W'(1) << (2*B));
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					sq_v[j+1] <= 1'b0;
				end else begin
					sq_v[j+1] <= sq_v[j];
				end
			end
			always_ff @(posedge clk) begin
				sq_c[j+1]    <= sq_c[j];
				sq_side[j+1] <= sq_side[j];
				if (sq_rem[j] >= delta) begin
					sq_rem[j+1]  <= sq_rem[j] - delta;
					sq_root[j+1] <= sq_root[j] | (ROOT_W'(1) << B);
				end else begin
					sq_rem[j+1]  <= sq_rem[j];
					sq_root[j+1] <= sq_root[j];
				end
			end
		end
	endgenerate

	// angle by CORDIC vectoring
	logic signed [XY_W-1:0] va_x [1];
	logic signed [XY_W-1:0] va_y [1];
	logic signed [Z_W-1:0]  va_z [1];
	logic signed [Z_W-1:0]  vo_z [1];
	side_t                  va_side;
	logic [SIDE_W-1:0]      vo_side;
	logic                   vo_valid;

	always_comb begin
		va_x[0]     = XY_W'(sq_c[SQ_N]);
		va_y[0]     = XY_W'(sq_root[SQ_N]);
		va_z[0]     = '0;
		va_side     = sq_side[SQ_N];
		va_side.lin = sq_side[SQ_N].lin || (sq_root[SQ_N] == '0);
	end

	qslerp_cordic #(
		.STEPS  (CORDIC_STEPS),
		.VECTOR (1'b1),
		.LANES  (1),
		.SIDE_W (SIDE_W)
	) u_vec (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sq_v[SQ_N]),
		.in_x      (va_x),
		.in_y      (va_y),
		.in_z      (va_z),
		.in_side   (va_side),
		.out_valid (vo_valid),
		.out_x     (),
		.out_y     (),
		.out_z     (vo_z),
		.out_side  (vo_side)
	);

	// stage A: partial angles
	logic                      v_sa;
	side_t                     side_sa;
	side_t                     vo_st;
	side_t                     side_na;
	logic signed [Z_W-1:0]     om_sa;
	logic signed [Z_W-1:0]     a1_sa;
	logic signed [Z_W-1:0]     a2_sa;
	logic signed [TF_W:0]      wp;
	logic signed [TF_W:0]      wq;
	logic signed [TF_W+Z_W:0]  m1;
	logic signed [TF_W+Z_W:0]  m2;

	always_comb begin
		vo_st       = side_t'(vo_side);
		side_na     = vo_st;
		side_na.lin = vo_st.lin || (vo_z[0] <= 0);
		wp          = (TF_W+1)'(ONE) - $signed({1'b0, vo_st.tf});
		wq          = $signed({1'b0, vo_st.tf});
		m1          = wp * vo_z[0];
		m2          = wq * vo_z[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sa <= 1'b0;
		end else begin
			v_sa <= vo_valid;
		end
	end

	always_ff @(posedge clk) begin
		side_sa <= side_na;
		om_sa   <= vo_z[0];
		a1_sa   <= Z_W'(m1 >>> FRAC);
		a2_sa   <= Z_W'(m2 >>> FRAC);
	end

	// three sines by CORDIC rotation
	logic signed [XY_W-1:0] ra_x [3];
	logic signed [XY_W-1:0] ra_y [3];
	logic signed [Z_W-1:0]  ra_z [3];
	logic signed [XY_W-1:0] ro_y [3];
	logic [SIDE_W-1:0]      ro_side;
	logic                   ro_valid;

	assign ra_x = '{XY_W'(ONE), XY_W'(ONE), XY_W'(ONE)};
	assign ra_y = '{XY_W'(0), XY_W'(0), XY_W'(0)};
	assign ra_z = '{om_sa, a1_sa, a2_sa};

	qslerp_cordic #(
		.STEPS  (CORDIC_STEPS),
		.VECTOR (1'b0),
		.LANES  (3),
		.SIDE_W (SIDE_W)
	) u_rot (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_sa),
		.in_x      (ra_x),
		.in_y      (ra_y),
		.in_z      (ra_z),
		.in_side   (side_sa),
		.out_valid (ro_valid),
		.out_x     (),
		.out_y     (ro_y),
		.out_z     (),
		.out_side  (ro_side)
	);

	// division: weight = sin(a) * ONE / sin(omega), one quotient bit per stage
	logic [DIV_W-1:0]   dv_rem   [DV_N+1][2];
	logic [QUO_W-1:0]   dv_quo   [DV_N+1][2];
	logic [1:0]         dv_clamp [DV_N+1];
	logic [1:0]         dv_sign  [DV_N+1];
	logic [DIV_W-1:0]   dv_sd    [DV_N+1];
	side_t              dv_side  [DV_N+1];
	logic [DV_N:0]      dv_v;
	side_t              ro_st;
	side_t              dv_side_n;
	logic [XY_W-1:0]    mag [2];
	logic [XY_W:0]      sd2;

	always_comb begin
		ro_st         = side_t'(ro_side);
		dv_side_n     = ro_st;
		dv_side_n.lin = ro_st.lin || (ro_y[0] <= 0);
		sd2           = {ro_y[0], 1'b0};
		for (int i = 0; i < 2; i++) begin
			mag[i] = (ro_y[i+1] < 0) ? XY_W'(-ro_y[i+1]) : XY_W'(ro_y[i+1]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v[0] <= 1'b0;
		end else begin
			dv_v[0] <= ro_valid;
		end
	end

	always_ff @(posedge clk) begin
		dv_side[0] <= dv_side_n;
		dv_sd[0]   <= DIV_W'(ro_y[0][XY_W-2:0]);
		for (int i = 0; i < 2; i++) begin
			dv_clamp[0][i] <= {1'b0, mag[i]} >= sd2;
			dv_sign[0][i]  <= ro_y[i+1] < 0;
			dv_rem[0][i]   <= ({1'b0, mag[i]} >= sd2) ? '0 : (DIV_W'(mag[i]) << FRAC);
			dv_quo[0][i]   <= '0;
		end
	end

	generate
		for (j = 0; j < DV_N; j++) begin : g_div
			localparam int B = DV_N - 1 - j;
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					dv_v[j+1] <= 1'b0;
				end else begin
					dv_v[j+1] <= dv_v[j];
				end
			end
			always_ff @(posedge clk) begin
				dv_side[j+1]  <= dv_side[j];
				dv_sd[j+1]    <= dv_sd[j];
				dv_clamp[j+1] <= dv_clamp[j];
				dv_sign[j+1]  <= dv_sign[j];
			end
			for (l = 0; l < 2; l++) begin : g_lane
				always_ff @(posedge clk) begin
					if (dv_rem[j][l] >= (dv_sd[j] << B)) begin
						dv_rem[j+1][l] <= dv_rem[j][l] - (dv_sd[j] << B);
						dv_quo[j+1][l] <= dv_quo[j][l] | (QUO_W'(1) << B);
					end else begin
						dv_rem[j+1][l] <= dv_rem[j][l];
						dv_quo[j+1][l] <= dv_quo[j][l];
					end
				end
			end
		end
	endgenerate

	// stage W: weight selection
	logic                    v_w;
	side_t                   side_w;
	logic signed [K_W-1:0]   kp_w;
	logic signed [K_W-1:0]   kq_w;
	logic signed [K_W-1:0]   kd [2];
	logic signed [K_W-1:0]   kp_n;
	logic signed [K_W-1:0]   kq_n;
	side_t                   ds;

	always_comb begin
		ds = dv_side[DV_N];
		for (int i = 0; i < 2; i++) begin
			kd[i] = dv_clamp[DV_N][i] ? K_W'(2*ONE) : K_W'(dv_quo[DV_N][i]);
			if (dv_sign[DV_N][i]) begin
				kd[i] = -kd[i];
			end
		end
		case (ds.mode)
			MODE_PASS_P: begin
				kp_n = K_W'(ONE);
				kq_n = '0;
			end
			MODE_PASS_Q: begin
				kp_n = '0;
				kq_n = K_W'(ONE);
			end
			MODE_BLEND: begin
				if (ds.lin) begin
					kp_n = K_W'(ONE) - K_W'(ds.tf);
					kq_n = K_W'(ds.tf);
				end else begin
					kp_n = kd[0];
					kq_n = kd[1];
				end
				if (ds.neg) begin
					kq_n = -kq_n;
				end
			end
			default: begin
				kp_n = K_W'(ONE);
				kq_n = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_w <= 1'b0;
		end else begin
			v_w <= dv_v[DV_N];
		end
	end

	always_ff @(posedge clk) begin
		side_w <= ds;
		kp_w   <= kp_n;
		kq_w   <= kq_n;
	end

	// stage M: weighted products
	logic                     v_m;
	logic signed [PROD_W-1:0] pp_m [4];
	logic signed [PROD_W-1:0] qq_m [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_m <= 1'b0;
		end else begin
			v_m <= v_w;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			pp_m[i] <= kp_w * $signed(side_w.p[i]);
			qq_m[i] <= kq_w * $signed(side_w.q[i]);
		end
	end

	// stage O: round, saturate
	logic signed [PROD_W:0]        acc [4];
	logic signed [PROD_W-FRAC:0]   rnd [4];
	logic signed [IO_W-1:0]        sat [4];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			acc[i] = (PROD_W+1)'(pp_m[i]) + (PROD_W+1)'(qq_m[i])
				+ (PROD_W+1)'(1 << (FRAC - 1));
			rnd[i] = (PROD_W-FRAC+1)'(acc[i] >>> FRAC);
			if (rnd[i] > 32767) begin
				sat[i] = 16'sh7fff;
			end else if (rnd[i] < -32768) begin
				sat[i] = 16'sh8000;
			end else begin
				sat[i] = IO_W'(rnd[i]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= v_m;
		end
	end

	always_ff @(posedge clk) begin
		out_w <= sat[0];
		out_x <= sat[1];
		out_y <= sat[2];
		out_z <= sat[3];
	end

	`QS_ASSERT_NEXT(a_out_follows, v_m, done, "product beat did not reach the output")
	`QS_ASSERT(a_done_source, done |-> $past(v_m), "result beat without a product beat")
	`QS_ASSERT(a_pass_p_weight,
		v_w && (side_w.mode == MODE_PASS_P) |-> (kq_w == 0),
		"start pass-through with nonzero end weight")
	`QS_ASSERT(a_weight_range,
		v_w |-> (kp_w <= 32768) && (kp_w >= -32768) && (kq_w <= 32768) && (kq_w >= -32768),
		"weight outside clamp range")

endmodule
